>>> rtl/core/fk_pkg.sv
// shared types, constants and helpers for the arm forward kinematics block
package fk_pkg;

    localparam int ANG_W     = 17;
    localparam int LEN_W     = 20;
    localparam int POS_W     = 23;
    localparam int CW        = 33;
    localparam int TRIG_W    = 20;
    localparam int CFG_IDX_W = 2;
    localparam int LANES     = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FORE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WRIST = 2'd2;

    localparam logic [LEN_W-1:0] UPPER_RST = 20'd200000;
    localparam logic [LEN_W-1:0] FORE_RST  = 20'd150000;
    localparam logic [LEN_W-1:0] WRIST_RST = 20'd80000;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;

    localparam logic [31:0] ATAN_TBL [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 neg;
    } t_lane;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [63:0] v);
        logic signed [POS_W-1:0] res;
        if (v > 64'sd4194303) begin
            res = 23'sd4194303;
        end else if (v < -64'sd4194304) begin
            res = -23'sd4194304;
        end else begin
            res = v[POS_W-1:0];
        end
        return res;
    endfunction

endpackage

>>> rtl/core/fk_angle_prep.sv
// angle reduction to a binary angle and quadrant fold, three stages
module fk_angle_prep (
    input  logic                           i_clk,
    input  logic signed [fk_pkg::ANG_W-1:0] i_angle,
    output fk_pkg::t_lane                  o_lane
);
    import fk_pkg::*;

    localparam logic [31:0] TURN_SCALE = 32'd119304;
    localparam logic [51:0] RECIP      = 52'd61083980;

    logic signed [17:0] w_ext;
    logic signed [17:0] w_red;
    logic [15:0]        w_a;
    logic [31:0]        r_p;
    logic [24:0]        r_t;
    logic [51:0]        w_prod;
    logic [31:0]        r_s;
    logic signed [CW-1:0] w_se;
    t_lane              n_lane;
    t_lane              r_lane;

    always_comb begin
        w_ext = 18'(i_angle);
        if (w_ext < -18'sd36000) begin
            w_red = w_ext + 18'sd72000;
        end else if (w_ext < 18'sd0) begin
            w_red = w_ext + 18'sd36000;
        end else if (w_ext >= 18'sd36000) begin
            w_red = w_ext - 18'sd36000;
        end else begin
            w_red = w_ext;
        end
        w_a = w_red[15:0];
    end

    assign w_prod = 52'(r_t) * RECIP;

    always_comb begin
        w_se       = CW'($signed(r_s));
        n_lane.x   = CORDIC_GAIN;
        n_lane.y   = '0;
        n_lane.z   = w_se;
        n_lane.neg = 1'b0;
        if (w_se > 33'sd1073741824) begin
            n_lane.z   = 33'sd2147483648 - w_se;
            n_lane.neg = 1'b1;
        end else if (w_se < -33'sd1073741824) begin
            n_lane.z   = -33'sd2147483648 - w_se;
            n_lane.neg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p    <= 32'(w_a) * TURN_SCALE;
        r_t    <= 25'(w_a) * 25'd728 + 25'd562;
        r_s    <= r_p + 32'(w_prod[51:36]);
        r_lane <= n_lane;
    end

    assign o_lane = r_lane;

endmodule

>>> rtl/core/fk_cordic_cell.sv
// one rotation-mode cordic stage for one angle lane
module fk_cordic_cell #(
    parameter int STAGE_IDX = 0
) (
    input  logic          i_clk,
    input  fk_pkg::t_lane i_lane,
    output fk_pkg::t_lane o_lane
);
    import fk_pkg::*;

    logic signed [CW-1:0] w_dx;
    logic signed [CW-1:0] w_dy;
    logic signed [CW-1:0] w_at;
    t_lane                n_lane;
    t_lane                r_lane;

    always_comb begin
        w_dx       = i_lane.y >>> STAGE_IDX;
        w_dy       = i_lane.x >>> STAGE_IDX;
        w_at       = $signed({1'b0, ATAN_TBL[STAGE_IDX]});
        n_lane.neg = i_lane.neg;
        if (!i_lane.z[CW-1]) begin
            n_lane.x = i_lane.x - w_dx;
            n_lane.y = i_lane.y + w_dy;
            n_lane.z = i_lane.z - w_at;
        end else begin
            n_lane.x = i_lane.x + w_dx;
            n_lane.y = i_lane.y - w_dy;
            n_lane.z = i_lane.z + w_at;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lane <= n_lane;
    end

    assign o_lane = r_lane;

endmodule

>>> rtl/core/fk_combine.sv
// trig rounding, link products, base rotation and saturation, six stages
module fk_combine (
    input  logic                            i_clk,
    input  fk_pkg::t_lane                   i_lanes [fk_pkg::LANES],
    input  logic [fk_pkg::LEN_W-1:0]        i_upper_len,
    input  logic [fk_pkg::LEN_W-1:0]        i_fore_len,
    input  logic [fk_pkg::LEN_W-1:0]        i_wrist_len,
    output logic signed [fk_pkg::POS_W-1:0] o_x_pos,
    output logic signed [fk_pkg::POS_W-1:0] o_y_pos,
    output logic signed [fk_pkg::POS_W-1:0] o_z_pos
);
    import fk_pkg::*;

    // lanes: shoulder, elbow, base, wrist
    logic signed [TRIG_W-1:0] r_c [LANES];
    logic signed [TRIG_W-1:0] r_s [LANES];
    logic signed [CW:0]       w_xr [LANES];
    logic signed [CW:0]       w_yr [LANES];

    logic signed [LEN_W:0]  w_l1, w_l2, w_l3;
    logic signed [40:0]     r_pr1, r_pr2, r_ph1, r_ph2, r_pwc, r_pws;
    logic signed [TRIG_W-1:0] r_cb1, r_sb1, r_cb2, r_sb2;
    logic signed [41:0]     r_r, r_h, r_h3, r_h4;
    logic signed [40:0]     r_pwc2, r_pws2, r_pwc3, r_pws3;
    logic signed [44:0]     r_mlo_c, r_mlo_s;
    logic signed [37:0]     r_mhi_c, r_mhi_s;
    logic signed [63:0]     r_xe, r_ye;
    logic signed [42:0]     w_hz;
    logic signed [POS_W-1:0] r_x, r_y, r_z;

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            w_xr[k] = (CW+1)'(i_lanes[k].x) + (CW+1)'(8192);
            w_yr[k] = (CW+1)'(i_lanes[k].y) + (CW+1)'(8192);
        end
        w_l1 = $signed({1'b0, i_upper_len});
        w_l2 = $signed({1'b0, i_fore_len});
        w_l3 = $signed({1'b0, i_wrist_len});
        w_hz = 43'(r_h4) + 43'sd32768;
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < LANES; k++) begin
            r_c[k] <= i_lanes[k].neg ? -w_xr[k][CW:14] : w_xr[k][CW:14];
            r_s[k] <= w_yr[k][CW:14];
        end
        // link and wrist products
        r_pr1 <= w_l1 * 41'(r_c[0]);
        r_pr2 <= w_l2 * 41'(r_c[1]);
        r_ph1 <= w_l1 * 41'(r_s[0]);
        r_ph2 <= w_l2 * 41'(r_s[1]);
        r_pwc <= w_l3 * 41'(r_c[3]);
        r_pws <= w_l3 * 41'(r_s[3]);
        r_cb1 <= r_c[2];
        r_sb1 <= r_s[2];
        // reach and height sums
        r_r    <= 42'(r_pr1) + 42'(r_pr2);
        r_h    <= 42'(r_ph1) + 42'(r_ph2);
        r_pwc2 <= r_pwc;
        r_pws2 <= r_pws;
        r_cb2  <= r_cb1;
        r_sb2  <= r_sb1;
        // reach times base trig, split in two partial products
        r_mlo_c <= 45'($signed({1'b0, r_r[23:0]})) * 45'(r_cb2);
        r_mlo_s <= 45'($signed({1'b0, r_r[23:0]})) * 45'(r_sb2);
        r_mhi_c <= 38'($signed(r_r[41:24])) * 38'(r_cb2);
        r_mhi_s <= 38'($signed(r_r[41:24])) * 38'(r_sb2);
        r_pwc3  <= r_pwc2;
        r_pws3  <= r_pws2;
        r_h3    <= r_h;
        // full sums with rounding bias
        r_xe <= (64'(r_mhi_c) <<< 24) + 64'(r_mlo_c) + (64'(r_pwc3) <<< 16)
                + 64'sd2147483648;
        r_ye <= (64'(r_mhi_s) <<< 24) + 64'(r_mlo_s) + (64'(r_pws3) <<< 16)
                + 64'sd2147483648;
        r_h4 <= r_h3;
        // round and saturate
        r_x <= sat_pos(64'($signed(r_xe[63:32])));
        r_y <= sat_pos(64'($signed(r_ye[63:32])));
        r_z <= sat_pos(64'($signed(w_hz[42:16])));
    end

    assign o_x_pos = r_x;
    assign o_y_pos = r_y;
    assign o_z_pos = r_z;

endmodule

>>> rtl/core/arm_forward_kinematics_top.sv
// top level of the arm forward kinematics pipeline
//
//  port group        dir  beat marker        payload
//  command           in   start & !busy      i_shoulder_angle, i_elbow_angle,
//                                            i_base_angle, i_wrist_heading
//  result            out  o_valid            o_x_pos, o_y_pos, o_z_pos
//  register write    in   i_cfg_we           i_cfg_idx, i_cfg_data
//
//  one command beat per cycle; busy is high only during reset
//  each result passes through these stages after its command beat:
//  3 angle reduction stages, one cordic cell per stage, 6 combine stages
//  synchronous active-low reset clears the valid pipeline and reloads the link lengths
//  results are shown for one cycle; the receiver cannot stall
module arm_forward_kinematics_top #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [fk_pkg::ANG_W-1:0]     i_shoulder_angle,
    input  logic signed [fk_pkg::ANG_W-1:0]     i_elbow_angle,
    input  logic signed [fk_pkg::ANG_W-1:0]     i_base_angle,
    input  logic signed [fk_pkg::ANG_W-1:0]     i_wrist_heading,
    input  logic                                i_cfg_we,
    input  logic [fk_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [fk_pkg::LEN_W-1:0]            i_cfg_data,
    output logic                                o_valid,
    output logic signed [fk_pkg::POS_W-1:0]     o_x_pos,
    output logic signed [fk_pkg::POS_W-1:0]     o_y_pos,
    output logic signed [fk_pkg::POS_W-1:0]     o_z_pos
);
    import fk_pkg::*;

    localparam int LAT = CORDIC_STAGES + 9;

    logic [LEN_W-1:0] r_upper_len;
    logic [LEN_W-1:0] r_fore_len;
    logic [LEN_W-1:0] r_wrist_len;
    logic [LAT-1:0]   r_valid;

    logic signed [ANG_W-1:0] w_ang [LANES];
    t_lane w_chain [LANES][CORDIC_STAGES+1];
    t_lane w_done  [LANES];

    assign busy = !i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper_len <= UPPER_RST;
            r_fore_len  <= FORE_RST;
            r_wrist_len <= WRIST_RST;
            r_valid     <= '0;
        end else begin
            r_valid <= {r_valid[LAT-2:0], start & !busy};
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_UPPER: r_upper_len <= i_cfg_data;
                    CFG_FORE:  r_fore_len  <= i_cfg_data;
                    CFG_WRIST: r_wrist_len <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign w_ang[0] = i_shoulder_angle;
    assign w_ang[1] = i_elbow_angle;
    assign w_ang[2] = i_base_angle;
    assign w_ang[3] = i_wrist_heading;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        fk_angle_prep u_prep (
            .i_clk   (i_clk),
            .i_angle (w_ang[g]),
            .o_lane  (w_chain[g][0])
        );
        for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_cell
            fk_cordic_cell #(
                .STAGE_IDX (s)
            ) u_cell (
                .i_clk  (i_clk),
                .i_lane (w_chain[g][s]),
                .o_lane (w_chain[g][s+1])
            );
        end
        assign w_done[g] = w_chain[g][CORDIC_STAGES];
    end

    fk_combine u_combine (
        .i_clk       (i_clk),
        .i_lanes     (w_done),
        .i_upper_len (r_upper_len),
        .i_fore_len  (r_fore_len),
        .i_wrist_len (r_wrist_len),
        .o_x_pos     (o_x_pos),
        .o_y_pos     (o_y_pos),
        .o_z_pos     (o_z_pos)
    );

    assign o_valid = r_valid[LAT-1];

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("result beat missing after command beat");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!start && !r_valid[0]) |=> !r_valid[0])
        else $error("pipeline valid raised without a command beat");

endmodule
